// ===== design/modbus_rtu_slave_data_engine_assert.svh =====
// Assertion macros for the Modbus RTU slave data engine.
`ifndef MODBUS_RTU_SLAVE_DATA_ENGINE_ASSERT_SVH
`define MODBUS_RTU_SLAVE_DATA_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MRSDE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mrsde assertion failed");
`define MRSDE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("mrsde assertion failed");
`else
`define MRSDE_ASSERT(lbl, prop)
`define MRSDE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/mrsde_pkg.sv =====
package mrsde_pkg;

  localparam int COIL_DEPTH      = 256;
  localparam int REG_DEPTH       = 256;
  localparam int MAX_REPLY_BYTES = 64;
  localparam int COIL_AW         = $clog2(COIL_DEPTH);
  localparam int REG_AW          = $clog2(REG_DEPTH);
  localparam int MAX_COIL_QTY    = (MAX_REPLY_BYTES - 5) * 8;
  localparam int MAX_REG_QTY     = (MAX_REPLY_BYTES - 5) / 2;
  localparam int QDEPTH          = 4;
  localparam int QAW             = $clog2(QDEPTH);

  localparam logic OP_HEADER = 1'b0;
  localparam logic OP_DATA   = 1'b1;

  localparam logic [7:0] FC_READ_COILS       = 8'd1;
  localparam logic [7:0] FC_READ_INPUTS      = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING     = 8'd3;
  localparam logic [7:0] FC_READ_INPUT_REGS  = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL       = 8'd5;
  localparam logic [7:0] FC_WRITE_REG        = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS      = 8'd15;
  localparam logic [7:0] FC_WRITE_REGS       = 8'd16;
  localparam logic [7:0] FC_READ_WRITE_REGS  = 8'd23;
  localparam logic [7:0] FC_NONE             = 8'd0;

  typedef enum logic [2:0] {
    CMD_COIL_WR  = 3'd0,
    CMD_REG_WR   = 3'd1,
    CMD_ECHO     = 3'd2,
    CMD_RD_BITS  = 3'd3,
    CMD_RD_WORDS = 3'd4
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e   kind;
    logic [7:0]  fc;
    logic [15:0] addr;
    logic [15:0] qty;
    logic [15:0] data;
    logic [3:0]  nbits;
  } cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== design/modbus_rtu_slave_data_engine.sv =====
// Flow: a request beat is registered in the front end and queued before the back end
// starts its reply; coil reads pass a read and an accumulate state per bit, register
// reads a read, latch, high-byte and low-byte state per word. The back end takes one
// queued item at a time, paced by each store's single port and the reply byte sequencer.
// Reset: asynchronous, active low; coil and register stores read as zero after reset
// (per-entry valid bits), device address returns to 1, no clearing pass.
module modbus_rtu_slave_data_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] start_address_i,
  input  logic [15:0] quantity_i,
  input  logic [15:0] write_start_address_i,
  input  logic [15:0] write_quantity_i,
  input  logic [7:0]  byte_count_i,
  input  logic [7:0]  data_byte_i,
  input  logic        data_last_i,
  output logic        reply_valid_o,
  input  logic        reply_stall_i,
  output logic [7:0]  reply_byte_o,
  output logic        reply_last_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i
);
  import mrsde_pkg::*;

  cmd_t       f_cmd, q_cmd;
  logic       f_valid, q_full, q_empty, q_pop, q_push;
  logic [7:0] dev_addr_q;

  assign cfg_ready_o = 1'b1;
  assign q_push      = f_valid & ~q_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 8'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  mrsde_front u_front (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .operation_i           (operation_i),
    .function_code_i       (function_code_i),
    .start_address_i       (start_address_i),
    .quantity_i            (quantity_i),
    .write_start_address_i (write_start_address_i),
    .write_quantity_i      (write_quantity_i),
    .byte_count_i          (byte_count_i),
    .data_byte_i           (data_byte_i),
    .data_last_i           (data_last_i),
    .cmd_valid_o           (f_valid),
    .cmd_o                 (f_cmd),
    .cmd_full_i            (q_full)
  );

  mrsde_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd),
    .empty_o (q_empty)
  );

  mrsde_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (q_cmd),
    .empty_i          (q_empty),
    .pop_o            (q_pop),
    .device_address_i (dev_addr_q),
    .reply_valid_o    (reply_valid_o),
    .reply_stall_i    (reply_stall_i),
    .reply_byte_o     (reply_byte_o),
    .reply_last_o     (reply_last_o)
  );

endmodule

// ===== design/mrsde_front.sv =====
module mrsde_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [7:0]        function_code_i,
  input  logic [15:0]       start_address_i,
  input  logic [15:0]       quantity_i,
  input  logic [15:0]       write_start_address_i,
  input  logic [15:0]       write_quantity_i,
  input  logic [7:0]        byte_count_i,
  input  logic [7:0]        data_byte_i,
  input  logic              data_last_i,
  output logic              cmd_valid_o,
  output mrsde_pkg::cmd_t   cmd_o,
  input  logic              cmd_full_i
);
  import mrsde_pkg::*;

  function automatic cmd_t mk_cmd(input cmd_kind_e kind, input logic [7:0] fc,
                                  input logic [15:0] addr, input logic [15:0] qty,
                                  input logic [15:0] data, input logic [3:0] nbits);
    cmd_t c;
    c.kind  = kind;
    c.fc    = fc;
    c.addr  = addr;
    c.qty   = qty;
    c.data  = data;
    c.nbits = nbits;
    return c;
  endfunction

  function automatic logic [15:0] clamp_bits(input logic [15:0] q);
    return (q > 16'(MAX_COIL_QTY)) ? 16'(MAX_COIL_QTY) : q;
  endfunction

  function automatic logic [15:0] clamp_words(input logic [15:0] q);
    return (q > 16'(MAX_REG_QTY)) ? 16'(MAX_REG_QTY) : q;
  endfunction

  function automatic cmd_t reply_of(input logic [7:0] fc, input logic [15:0] a,
                                    input logic [15:0] q);
    cmd_t c;
    if (fc == FC_READ_WRITE_REGS) begin
      c = mk_cmd(CMD_RD_WORDS, fc, a, clamp_words(q), 16'd0, 4'd0);
    end else begin
      c = mk_cmd(CMD_ECHO, fc, a, q, 16'd0, 4'd0);
    end
    return c;
  endfunction

  cmd_t        a_q, a_d, b_q, b_d;
  logic        a_v_q, a_v_d, b_v_q, b_v_d;
  logic [7:0]  pf_q, pf_d;
  logic [15:0] ps_q, ps_d, pq_q, pq_d, pws_q, pws_d, pwq_q, pwq_d;
  logic [7:0]  pbc_q, pbc_d, di_q, di_d, hbl_q, hbl_d;
  logic [15:0] iw_q, iw_d;
  logic [15:0] rem, base, lim;
  logic [3:0]  nb;
  logic        accept, push;

  assign in_stall_o  = a_v_q | b_v_q;
  assign accept      = in_valid_i & ~in_stall_o;
  assign cmd_valid_o = a_v_q | b_v_q;
  assign cmd_o       = a_v_q ? a_q : b_q;
  assign push        = cmd_valid_o & ~cmd_full_i;

  always_comb begin
    a_d   = a_q;
    b_d   = b_q;
    a_v_d = a_v_q;
    b_v_d = b_v_q;
    pf_d  = pf_q;
    ps_d  = ps_q;
    pq_d  = pq_q;
    pws_d = pws_q;
    pwq_d = pwq_q;
    pbc_d = pbc_q;
    di_d  = di_q;
    iw_d  = iw_q;
    hbl_d = hbl_q;
    rem   = pq_q - iw_q;
    nb    = (rem >= 16'd8) ? 4'd8 : rem[3:0];
    base  = (pf_q == FC_READ_WRITE_REGS) ? pws_q : ps_q;
    lim   = (pf_q == FC_READ_WRITE_REGS) ? pwq_q : pq_q;
    if (push) begin
      if (a_v_q) begin
        a_v_d = 1'b0;
      end else begin
        b_v_d = 1'b0;
      end
    end
    if (accept) begin
      if (operation_i == OP_HEADER) begin
        pf_d  = FC_NONE;
        ps_d  = start_address_i;
        pq_d  = quantity_i;
        pws_d = write_start_address_i;
        pwq_d = write_quantity_i;
        pbc_d = byte_count_i;
        di_d  = 8'd0;
        iw_d  = 16'd0;
        hbl_d = 8'd0;
        unique case (function_code_i)
          FC_READ_COILS, FC_READ_INPUTS: begin
            b_v_d = 1'b1;
            b_d   = mk_cmd(CMD_RD_BITS, function_code_i, start_address_i,
                           clamp_bits(quantity_i), 16'd0, 4'd0);
          end
          FC_READ_HOLDING, FC_READ_INPUT_REGS: begin
            b_v_d = 1'b1;
            b_d   = mk_cmd(CMD_RD_WORDS, function_code_i, start_address_i,
                           clamp_words(quantity_i), 16'd0, 4'd0);
          end
          FC_WRITE_COIL: begin
            a_v_d = 1'b1;
            a_d   = mk_cmd(CMD_COIL_WR, function_code_i, start_address_i, quantity_i,
                           {15'd0, quantity_i != 16'd0}, 4'd1);
            b_v_d = 1'b1;
            b_d   = mk_cmd(CMD_ECHO, function_code_i, start_address_i, quantity_i,
                           16'd0, 4'd0);
          end
          FC_WRITE_REG: begin
            a_v_d = 1'b1;
            a_d   = mk_cmd(CMD_REG_WR, function_code_i, start_address_i, quantity_i,
                           quantity_i, 4'd0);
            b_v_d = 1'b1;
            b_d   = mk_cmd(CMD_ECHO, function_code_i, start_address_i, quantity_i,
                           16'd0, 4'd0);
          end
          FC_WRITE_COILS, FC_WRITE_REGS, FC_READ_WRITE_REGS: begin
            pf_d = function_code_i;
            if (byte_count_i == 8'd0) begin
              pf_d  = FC_NONE;
              b_v_d = 1'b1;
              b_d   = reply_of(function_code_i, start_address_i, quantity_i);
            end
          end
          default: begin
          end
        endcase
      end else if (pf_q != FC_NONE) begin
        if (pf_q == FC_WRITE_COILS) begin
          if (iw_q < pq_q) begin
            a_v_d = 1'b1;
            a_d   = mk_cmd(CMD_COIL_WR, pf_q, ps_q + iw_q, pq_q, {8'd0, data_byte_i}, nb);
            iw_d  = iw_q + {12'd0, nb};
          end
        end else begin
          if (!di_q[0]) begin
            hbl_d = data_byte_i;
          end else if (iw_q < lim) begin
            a_v_d = 1'b1;
            a_d   = mk_cmd(CMD_REG_WR, pf_q, base + iw_q, lim, {hbl_q, data_byte_i}, 4'd0);
            iw_d  = iw_q + 16'd1;
          end
        end
        if (data_last_i || ({1'b0, di_q} + 9'd1 >= {1'b0, pbc_q})) begin
          pf_d  = FC_NONE;
          b_v_d = 1'b1;
          b_d   = reply_of(pf_q, ps_q, pq_q);
        end else begin
          di_d = di_q + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      pf_q  <= FC_NONE;
      ps_q  <= '0;
      pq_q  <= '0;
      pws_q <= '0;
      pwq_q <= '0;
      pbc_q <= '0;
      di_q  <= '0;
      iw_q  <= '0;
      hbl_q <= '0;
    end else begin
      a_v_q <= a_v_d;
      b_v_q <= b_v_d;
      pf_q  <= pf_d;
      ps_q  <= ps_d;
      pq_q  <= pq_d;
      pws_q <= pws_d;
      pwq_q <= pwq_d;
      pbc_q <= pbc_d;
      di_q  <= di_d;
      iw_q  <= iw_d;
      hbl_q <= hbl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

endmodule

// ===== design/mrsde_queue.sv =====
`include "modbus_rtu_slave_data_engine_assert.svh"

module mrsde_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mrsde_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output mrsde_pkg::cmd_t cmd_o,
  output logic            empty_o
);
  import mrsde_pkg::*;

  cmd_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QDEPTH[QAW:0]);
  assign empty_o = (cnt_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + {{QAW{1'b0}}, push_i} - {{QAW{1'b0}}, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  `MRSDE_ASSERT(a_no_overflow, push_i |-> !full_o)
  `MRSDE_ASSERT(a_no_underflow, pop_i |-> !empty_o)
  `MRSDE_ASSERT(a_count_up, (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
  `MRSDE_ASSERT_ALWAYS(a_count_range, !rst_ni || (cnt_q <= QDEPTH[QAW:0]))

endmodule

// ===== design/mrsde_back.sv =====
module mrsde_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mrsde_pkg::cmd_t cmd_i,
  input  logic            empty_i,
  output logic            pop_o,
  input  logic [7:0]      device_address_i,
  output logic            reply_valid_o,
  input  logic            reply_stall_i,
  output logic [7:0]      reply_byte_o,
  output logic            reply_last_o
);
  import mrsde_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE  = 16'h0001,
    S_CWR   = 16'h0002,
    S_RWR   = 16'h0004,
    S_DEV   = 16'h0008,
    S_FC    = 16'h0010,
    S_ECHO  = 16'h0020,
    S_BCNT  = 16'h0040,
    S_BRD   = 16'h0080,
    S_BACC  = 16'h0100,
    S_BEMIT = 16'h0200,
    S_WRD   = 16'h0400,
    S_WLAT  = 16'h0800,
    S_WHI   = 16'h1000,
    S_WLO   = 16'h2000,
    S_CRCL  = 16'h4000,
    S_CRCH  = 16'h8000
  } state_e;

  state_e      state_q, state_d;
  cmd_t        cur_q, cur_d;
  logic [9:0]  cnt_q, cnt_d;
  logic [7:0]  acc_q, acc_d;
  logic [15:0] word_q, word_d;
  logic [15:0] crc_q, crc_d;
  logic        out_v_q, out_v_d, out_last_q, out_last_d;
  logic [7:0]  out_byte_q, out_byte_d;

  logic        coil_mem [COIL_DEPTH];
  logic        coil_vld_q [COIL_DEPTH];
  logic [15:0] reg_mem [REG_DEPTH];
  logic        reg_vld_q [REG_DEPTH];
  logic        coil_mem_rd_q, coil_vld_rd_q, reg_vld_rd_q;
  logic [15:0] reg_mem_rd_q;

  logic [15:0]       idx_sum;
  logic [COIL_AW-1:0] coil_idx;
  logic [REG_AW-1:0]  reg_idx;
  logic              coil_we, reg_we, coil_bit;
  logic              can_emit, emit, emit_last, crc_upd;
  logic [7:0]        emit_byte, bcount;
  logic [15:0]       coil_bcnt;

  assign idx_sum   = cur_q.addr + {6'd0, cnt_q};
  assign coil_idx  = idx_sum[COIL_AW-1:0];
  assign reg_idx   = idx_sum[REG_AW-1:0];
  assign can_emit  = ~out_v_q | ~reply_stall_i;
  assign coil_bit  = coil_mem_rd_q & coil_vld_rd_q;
  assign coil_bcnt = (cur_q.qty + 16'd7) >> 3;
  assign bcount    = (cur_q.kind == CMD_RD_BITS) ? coil_bcnt[7:0] : {cur_q.qty[6:0], 1'b0};

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    word_d    = word_q;
    crc_d     = crc_q;
    pop_o     = 1'b0;
    coil_we   = 1'b0;
    reg_we    = 1'b0;
    emit      = 1'b0;
    emit_last = 1'b0;
    emit_byte = 8'd0;
    crc_upd   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          cur_d = cmd_i;
          cnt_d = '0;
          acc_d = '0;
          unique case (cmd_i.kind)
            CMD_COIL_WR: state_d = S_CWR;
            CMD_REG_WR:  state_d = S_RWR;
            default:     state_d = S_DEV;
          endcase
        end
      end
      S_CWR: begin
        coil_we = 1'b1;
        if (cnt_q == {6'd0, cur_q.nbits} - 10'd1) begin
          state_d = S_IDLE;
        end else begin
          cnt_d = cnt_q + 10'd1;
        end
      end
      S_RWR: begin
        reg_we  = 1'b1;
        state_d = S_IDLE;
      end
      S_DEV: begin
        emit_byte = device_address_i;
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_FC;
        end
      end
      S_FC: begin
        emit_byte = cur_q.fc;
        if (can_emit) begin
          emit    = 1'b1;
          state_d = (cur_q.kind == CMD_ECHO) ? S_ECHO : S_BCNT;
        end
      end
      S_ECHO: begin
        unique case (cnt_q[1:0])
          2'd0:    emit_byte = cur_q.addr[15:8];
          2'd1:    emit_byte = cur_q.addr[7:0];
          2'd2:    emit_byte = cur_q.qty[15:8];
          default: emit_byte = cur_q.qty[7:0];
        endcase
        if (can_emit) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 10'd1;
          if (cnt_q[1:0] == 2'd3) begin
            state_d = S_CRCL;
          end
        end
      end
      S_BCNT: begin
        emit_byte = bcount;
        if (can_emit) begin
          emit = 1'b1;
          if (cur_q.qty == 16'd0) begin
            state_d = S_CRCL;
          end else begin
            state_d = (cur_q.kind == CMD_RD_BITS) ? S_BRD : S_WRD;
          end
        end
      end
      S_BRD: begin
        state_d = S_BACC;
      end
      S_BACC: begin
        if (({6'd0, cnt_q} < cur_q.qty) && coil_bit) begin
          acc_d = acc_q | (8'd1 << cnt_q[2:0]);
        end
        cnt_d   = cnt_q + 10'd1;
        state_d = (cnt_q[2:0] == 3'd7) ? S_BEMIT : S_BRD;
      end
      S_BEMIT: begin
        emit_byte = acc_q;
        if (can_emit) begin
          emit    = 1'b1;
          acc_d   = '0;
          state_d = ({6'd0, cnt_q} >= cur_q.qty) ? S_CRCL : S_BRD;
        end
      end
      S_WRD: begin
        state_d = S_WLAT;
      end
      S_WLAT: begin
        word_d  = reg_vld_rd_q ? reg_mem_rd_q : 16'd0;
        state_d = S_WHI;
      end
      S_WHI: begin
        emit_byte = word_q[15:8];
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_WLO;
        end
      end
      S_WLO: begin
        emit_byte = word_q[7:0];
        if (can_emit) begin
          emit  = 1'b1;
          cnt_d = cnt_q + 10'd1;
          state_d = ({6'd0, cnt_q} + 16'd1 >= cur_q.qty) ? S_CRCL : S_WRD;
        end
      end
      S_CRCL: begin
        crc_upd   = 1'b0;
        emit_byte = crc_q[7:0];
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_CRCH;
        end
      end
      S_CRCH: begin
        crc_upd   = 1'b0;
        emit_byte = crc_q[15:8];
        emit_last = 1'b1;
        if (can_emit) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (emit && crc_upd) begin
      crc_d = crc16_byte((state_q == S_DEV) ? 16'hFFFF : crc_q, emit_byte);
    end
  end

  always_comb begin
    out_v_d    = out_v_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_v_d    = 1'b1;
      out_byte_d = emit_byte;
      out_last_d = emit_last;
    end else if (!reply_stall_i) begin
      out_v_d = 1'b0;
    end
  end

  assign reply_valid_o = out_v_q;
  assign reply_byte_o  = out_byte_q;
  assign reply_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    cnt_q      <= cnt_d;
    acc_q      <= acc_d;
    word_q     <= word_d;
    crc_q      <= crc_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < COIL_DEPTH; i++) begin
        coil_vld_q[i] <= 1'b0;
      end
      coil_vld_rd_q <= 1'b0;
    end else begin
      if (coil_we) begin
        coil_vld_q[coil_idx] <= 1'b1;
      end
      coil_vld_rd_q <= coil_vld_q[coil_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (coil_we) begin
      coil_mem[coil_idx] <= cur_q.data[cnt_q[2:0]];
    end
    coil_mem_rd_q <= coil_mem[coil_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_DEPTH; i++) begin
        reg_vld_q[i] <= 1'b0;
      end
      reg_vld_rd_q <= 1'b0;
    end else begin
      if (reg_we) begin
        reg_vld_q[reg_idx] <= 1'b1;
      end
      reg_vld_rd_q <= reg_vld_q[reg_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (reg_we) begin
      reg_mem[reg_idx] <= cur_q.data;
    end
    reg_mem_rd_q <= reg_mem[reg_idx];
  end

endmodule

// ===== tb/sv/modbus_rtu_slave_data_engine_tb.sv =====
`timescale 1ns / 100ps
module modbus_rtu_slave_data_engine_tb;
  import mrsde_pkg::*;

  typedef struct {
    logic [7:0] rbyte;
    logic       rlast;
  } reply_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OP_HEADER;
  logic [7:0]  function_code_i = '0;
  logic [15:0] start_address_i = '0;
  logic [15:0] quantity_i = '0;
  logic [15:0] write_start_address_i = '0;
  logic [15:0] write_quantity_i = '0;
  logic [7:0]  byte_count_i = '0;
  logic [7:0]  data_byte_i = '0;
  logic        data_last_i = 1'b0;
  logic        reply_valid_o;
  logic        reply_stall_i = 1'b0;
  logic [7:0]  reply_byte_o;
  logic        reply_last_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;

  modbus_rtu_slave_data_engine dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  logic [7:0]  dev_addr;
  logic        coil_mem [COIL_DEPTH];
  logic [15:0] reg_mem [REG_DEPTH];
  logic [7:0]  pend_fc;
  logic [15:0] pend_start, pend_qty, pend_wstart, pend_wqty, n_written;
  logic [7:0]  pend_bc, data_idx, hi_latch;

  reply_beat_t reply_q[$];
  logic [7:0]  frame_buf[$];
  int          mismatches = 0;
  int          cycles = 0;
  bit          stall_ctl = 1'b1;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void put_b(logic [7:0] b);
    if (frame_buf.size() < MAX_REPLY_BYTES) frame_buf.push_back(b);
  endfunction

  function automatic void begin_frame(logic [7:0] fc);
    frame_buf.delete();
    put_b(dev_addr);
    put_b(fc);
  endfunction

  function automatic void close_frame();
    logic [15:0] crc;
    reply_beat_t rb;
    crc = 16'hFFFF;
    foreach (frame_buf[i]) begin
      crc ^= {8'h00, frame_buf[i]};
      for (int k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
    end
    put_b(crc[7:0]);
    put_b(crc[15:8]);
    foreach (frame_buf[i]) begin
      rb.rbyte = frame_buf[i];
      rb.rlast = (i == frame_buf.size() - 1);
      reply_q.push_back(rb);
    end
  endfunction

  function automatic void coil_reply(logic [7:0] fc, logic [15:0] sa, logic [15:0] qt);
    int q, nb;
    logic [7:0] v;
    logic [15:0] a;
    q = (qt > MAX_COIL_QTY) ? MAX_COIL_QTY : qt;
    nb = (q + 7) / 8;
    begin_frame(fc);
    put_b(nb[7:0]);
    for (int i = 0; i < nb; i++) begin
      v = '0;
      for (int k = 0; k < 8; k++) begin
        a = sa + 16'(i * 8 + k);
        if (i * 8 + k < q && coil_mem[a % COIL_DEPTH]) v[k] = 1'b1;
      end
      put_b(v);
    end
    close_frame();
  endfunction

  function automatic void word_reply(logic [7:0] fc, logic [15:0] sa, logic [15:0] qt);
    int q;
    logic [15:0] a;
    q = (qt > MAX_REG_QTY) ? MAX_REG_QTY : qt;
    begin_frame(fc);
    put_b(8'(q * 2));
    for (int i = 0; i < q; i++) begin
      a = sa + 16'(i);
      put_b(reg_mem[a % REG_DEPTH][15:8]);
      put_b(reg_mem[a % REG_DEPTH][7:0]);
    end
    close_frame();
  endfunction

  function automatic void echo_reply(logic [7:0] fc, logic [15:0] a, logic [15:0] q);
    begin_frame(fc);
    put_b(a[15:8]); put_b(a[7:0]); put_b(q[15:8]); put_b(q[7:0]);
    close_frame();
  endfunction

  function automatic void finish_write();
    logic [7:0] fc;
    fc = pend_fc;
    pend_fc = FC_NONE;
    if (fc == FC_READ_WRITE_REGS) word_reply(fc, pend_start, pend_qty);
    else echo_reply(fc, pend_start, pend_qty);
  endfunction

  function automatic void predict_beat(logic op, logic [7:0] fc, logic [15:0] sa,
                                       logic [15:0] qt, logic [15:0] wsa, logic [15:0] wq,
                                       logic [7:0] bc, logic [7:0] db, logic last);
    logic [15:0] a, base, lim;
    if (op == OP_HEADER) begin
      pend_fc = FC_NONE; pend_start = sa; pend_qty = qt; pend_wstart = wsa;
      pend_wqty = wq; pend_bc = bc; data_idx = '0; n_written = '0; hi_latch = '0;
      case (fc)
        FC_READ_COILS, FC_READ_INPUTS: coil_reply(fc, sa, qt);
        FC_READ_HOLDING, FC_READ_INPUT_REGS: word_reply(fc, sa, qt);
        FC_WRITE_COIL: begin
          coil_mem[sa % COIL_DEPTH] = (qt != 0);
          echo_reply(fc, sa, qt);
        end
        FC_WRITE_REG: begin
          reg_mem[sa % REG_DEPTH] = qt;
          echo_reply(fc, sa, qt);
        end
        FC_WRITE_COILS, FC_WRITE_REGS, FC_READ_WRITE_REGS: begin
          pend_fc = fc;
          if (bc == 0) finish_write();
        end
        default: ;
      endcase
      return;
    end
    if (pend_fc == FC_NONE) return;
    if (pend_fc == FC_WRITE_COILS) begin
      for (int k = 0; k < 8; k++)
        if (n_written < pend_qty) begin
          a = pend_start + n_written;
          coil_mem[a % COIL_DEPTH] = db[k];
          n_written++;
        end
    end else begin
      base = (pend_fc == FC_READ_WRITE_REGS) ? pend_wstart : pend_start;
      lim  = (pend_fc == FC_READ_WRITE_REGS) ? pend_wqty : pend_qty;
      if (!data_idx[0]) hi_latch = db;
      else if (n_written < lim) begin
        a = base + n_written;
        reg_mem[a % REG_DEPTH] = {hi_latch, db};
        n_written++;
      end
    end
    if (last || 9'(data_idx) + 9'd1 >= 9'(pend_bc)) finish_write();
    else data_idx++;
  endfunction

  task automatic send_beat(logic op, logic [7:0] fc, logic [15:0] sa, logic [15:0] qt,
                           logic [15:0] wsa, logic [15:0] wq, logic [7:0] bc,
                           logic [7:0] db, logic last);
    int g;
    g = rand_gap();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op; function_code_i <= fc; start_address_i <= sa; quantity_i <= qt;
    write_start_address_i <= wsa; write_quantity_i <= wq; byte_count_i <= bc;
    data_byte_i <= db; data_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    predict_beat(op, fc, sa, qt, wsa, wq, bc, db, last);
  endtask

  task automatic send_header(logic [7:0] fc, logic [15:0] sa, logic [15:0] qt,
                             logic [7:0] bc = 0, logic [15:0] wsa = 0, logic [15:0] wq = 0);
    send_beat(OP_HEADER, fc, sa, qt, wsa, wq, bc, 8'($urandom), 1'($urandom));
  endtask

  task automatic send_data(logic [7:0] db, logic last);
    send_beat(OP_DATA, 8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 8'($urandom), db, last);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (reply_q.size() != 0) @(posedge clk_i);
    repeat (600) @(posedge clk_i);
  endtask

  task automatic write_dev_addr(logic [7:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dev_addr = v;
  endtask

  always @(posedge clk_i) begin
    reply_beat_t exp_b;
    if (rst_ni && reply_valid_o && !reply_stall_i) begin
      if (reply_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected reply beat %h last %b", reply_byte_o,
                                       reply_last_o);
      end else begin
        exp_b = reply_q.pop_front();
        if (exp_b.rbyte !== reply_byte_o || exp_b.rlast !== reply_last_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reply mismatch: expected %h/%b actual %h/%b", exp_b.rbyte,
                     exp_b.rlast, reply_byte_o, reply_last_o);
        end
      end
    end
    reply_stall_i <= stall_ctl ? ($urandom_range(0, 99) < 25) : 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic rand_write_data(logic [7:0] n);
    for (int i = 0; i < n; i++) send_data(8'($urandom), (i == n - 1));
  endtask

  task automatic test_directed();
    send_header(FC_READ_COILS, 16'h0000, 16'h0000);
    send_header(FC_WRITE_COIL, 16'hFFFF, 16'hFF00);
    send_header(FC_WRITE_REG, 16'hFFFF, 16'hFFFF);
    send_header(FC_READ_COILS, 16'hFFF8, 16'hFFFF);
    send_header(FC_READ_INPUTS, 16'h00FF, 16'd9);
    send_header(FC_READ_HOLDING, 16'hFFFE, 16'hFFFF);
    send_header(FC_READ_INPUT_REGS, 16'h0000, 16'd0);
    send_header(FC_WRITE_COIL, 16'h0001, 16'h0000);
    send_header(8'hFF, 16'h1234, 16'h0003);
    send_header(FC_NONE, 16'h1234, 16'h0003);
    send_data(8'hA5, 1'b1);
    send_header(FC_WRITE_COILS, 16'hFFFC, 16'd10, 8'd3);
    send_data(8'hFF, 1'b0); send_data(8'hFF, 1'b0); send_data(8'h00, 1'b0);
    send_header(FC_WRITE_REGS, 16'h0010, 16'd1, 8'd0);
    send_header(FC_WRITE_REGS, 16'h0010, 16'd2, 8'd5);
    send_data(8'h12, 1'b0); send_data(8'h34, 1'b0); send_data(8'hAB, 1'b0);
    send_data(8'hCD, 1'b0); send_data(8'hEF, 1'b0);
    send_header(FC_WRITE_REGS, 16'h0020, 16'd4, 8'd8);
    send_data(8'h55, 1'b0);
    send_header(FC_READ_WRITE_REGS, 16'h000E, 16'd6, 8'd4, 16'hFFFF, 16'd2);
    send_data(8'hDE, 1'b0); send_data(8'hAD, 1'b0); send_data(8'hBE, 1'b1);
    drain();
  endtask

  task automatic test_random();
    int kind;
    logic [7:0] fc, bc;
    for (int n = 0; n < 70; n++) begin
      kind = $urandom_range(0, 99);
      fc = (kind < 10) ? 8'($urandom) : (kind < 30) ? 8'($urandom_range(1, 4)) :
           (kind < 45) ? 8'($urandom_range(5, 6)) :
           (kind < 60) ? FC_WRITE_COILS : (kind < 80) ? FC_WRITE_REGS : FC_READ_WRITE_REGS;
      bc = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
      send_header(fc, ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                  ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
                  bc, 16'($urandom_range(0, 300)),
                  ($urandom_range(0, 5) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8)));
      if (fc == FC_WRITE_COILS || fc == FC_WRITE_REGS || fc == FC_READ_WRITE_REGS) begin
        if ($urandom_range(0, 7) == 0) rand_write_data(8'($urandom_range(0, bc)));
        else if (bc <= 16) for (int i = 0; i < bc; i++) send_data(8'($urandom), 1'b0);
        else rand_write_data(8'($urandom_range(1, 16)));
      end
      if (n == 35) drain();
      if (n == 42) stall_ctl = 1'b0;
      if (n == 50) stall_ctl = 1'b1;
    end
    drain();
  endtask

  task automatic test_dev_addr();
    write_dev_addr(8'h00);
    send_header(FC_READ_HOLDING, 16'h0010, 16'd3);
    drain();
    write_dev_addr(8'hFF);
    send_header(FC_WRITE_REG, 16'h0005, 16'hBEEF);
    drain();
    write_dev_addr(8'($urandom));
  endtask

  initial begin
    dev_addr = 8'd1;
    pend_fc = FC_NONE; pend_start = '0; pend_qty = '0; pend_wstart = '0; pend_wqty = '0;
    pend_bc = '0; data_idx = '0; n_written = '0; hi_latch = '0;
    foreach (coil_mem[i]) coil_mem[i] = 1'b0;
    foreach (reg_mem[i]) reg_mem[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_dev_addr();
    test_random();
    if (mismatches == 0 && reply_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== modbus_rtu_slave_data_engine.f =====
+incdir+design
design/mrsde_pkg.sv
design/mrsde_front.sv
design/mrsde_queue.sv
design/mrsde_back.sv
design/modbus_rtu_slave_data_engine.sv
tb/sv/modbus_rtu_slave_data_engine_tb.sv
